// ----- sv/psg_tone_noise_generator_assert.svh -----
// Assertion macros for the tone and noise generator
`ifndef PSG_TONE_NOISE_GENERATOR_ASSERT_SVH
`define PSG_TONE_NOISE_GENERATOR_ASSERT_SVH
`ifndef SYNTH
// same-cycle implication, disabled in reset
`define PSG_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication, disabled in reset
`define PSG_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define PSG_ASSERT_IMP(label, clk, rstn, ante, cons)
`define PSG_ASSERT_NXT(label, clk, rstn, ante, cons)
`endif
`endif

// ----- sv/psg_pkg.sv -----
// Package with the constants, codes and volume table of the tone and noise generator
package psg_pkg;

    localparam int ChCount = 3;

    // register select codes
    localparam logic [2:0] SEL_TONE0_PERIOD = 3'd0;
    localparam logic [2:0] SEL_TONE0_ATTEN  = 3'd1;
    localparam logic [2:0] SEL_TONE1_PERIOD = 3'd2;
    localparam logic [2:0] SEL_TONE1_ATTEN  = 3'd3;
    localparam logic [2:0] SEL_TONE2_PERIOD = 3'd4;
    localparam logic [2:0] SEL_TONE2_ATTEN  = 3'd5;
    localparam logic [2:0] SEL_NOISE_CTRL   = 3'd6;
    localparam logic [2:0] SEL_NOISE_ATTEN  = 3'd7;

    // noise rate codes
    localparam logic [1:0] NOISE_RATE_16   = 2'd0;
    localparam logic [1:0] NOISE_RATE_32   = 2'd1;
    localparam logic [1:0] NOISE_RATE_64   = 2'd2;
    localparam logic [1:0] NOISE_RATE_TONE = 2'd3;

    localparam logic [15:0] NOISE_SEED  = 16'h8000;
    localparam logic [3:0]  ATTEN_MUTE  = 4'hF;
    localparam logic [9:0]  COUNT_FIRST = 10'd1;

    typedef logic [9:0]  period_t;
    typedef logic [12:0] volume_t;

    // attenuation to linear volume
    function automatic volume_t vol_lookup(input logic [3:0] atten);
        volume_t v;
        case (atten)
            4'd0:    v = 13'd4096;
            4'd1:    v = 13'd3254;
            4'd2:    v = 13'd2584;
            4'd3:    v = 13'd2053;
            4'd4:    v = 13'd1631;
            4'd5:    v = 13'd1295;
            4'd6:    v = 13'd1029;
            4'd7:    v = 13'd817;
            4'd8:    v = 13'd649;
            4'd9:    v = 13'd516;
            4'd10:   v = 13'd410;
            4'd11:   v = 13'd325;
            4'd12:   v = 13'd258;
            4'd13:   v = 13'd205;
            4'd14:   v = 13'd163;
            default: v = 13'd0;
        endcase
        return v;
    endfunction

    // a zero period counts as one
    function automatic period_t period_or_one(input period_t p);
        return (p == 10'd0) ? 10'd1 : p;
    endfunction

    // signed contribution of one channel
    function automatic logic signed [15:0] vol_term(input logic [3:0] atten,
                                                     input logic level);
        logic signed [15:0] v;
        v = signed'({3'b000, vol_lookup(atten)});
        return level ? v : -v;
    endfunction

endpackage

// ----- sv/psg_tone_noise_generator.sv -----
// Tone and noise sound generator: port writes, clock ticks and the mixed sample
//
// Takes one item per clock, each either a byte written to the sound port (s_tuser = 0)
// or one divided clock tick (s_tuser = 1), and returns one mixed sample per item.
// An item is held in an input register; once it advances, the register write or tick
// updates the three tone channels and the noise channel in parallel, and the four-channel
// mix of the updated state is loaded into the result register, which drives m_tvalid;
// a stalled result holds the item in the input register. Sustained rate is one item per clock,
// limited only by m_tready. The sample is the sum of the four signed channel volumes
// shifted right by two, from -4096 to 4096, in m_tdata[13:0].
`include "psg_tone_noise_generator_assert.svh"

module psg_tone_noise_generator
    import psg_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] action (1 = tick, 0 = port write)
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // [13:0] mixed_sample (signed), [15:14] zero
);

    // input stage
    logic       in_valid_reg;
    logic       in_action_reg;
    logic [7:0] in_byte_reg;

    // result stage
    logic               out_valid_reg;
    logic signed [13:0] mix_reg;
    logic signed [13:0] mix_next;

    // generator state
    period_t     tone_period_reg [ChCount];
    period_t     tone_period_next [ChCount];
    period_t     tone_count_reg [ChCount];
    period_t     tone_count_next [ChCount];
    logic        tone_level_reg [ChCount];
    logic        tone_level_next [ChCount];
    logic [3:0]  tone_atten_reg [ChCount];
    logic [3:0]  tone_atten_next [ChCount];
    period_t     noise_count_reg;
    period_t     noise_count_next;
    logic [15:0] noise_shift_reg;
    logic [15:0] noise_shift_next;
    logic        noise_phase_reg;
    logic        noise_phase_next;
    logic        noise_bit_reg;
    logic        noise_bit_next;
    logic [1:0]  noise_rate_reg;
    logic [1:0]  noise_rate_next;
    logic        noise_white_reg;
    logic        noise_white_next;
    logic [3:0]  noise_atten_reg;
    logic [3:0]  noise_atten_next;
    logic [2:0]  reg_select_reg;
    logic [2:0]  reg_select_next;

    // working values
    logic               advance;
    logic               out_blocked;
    logic               tone_count_ok;
    logic [2:0]         sel_eff;
    logic               low_write;
    period_t            tone_dec [ChCount];
    period_t            noise_dec;
    logic signed [15:0] mix_sum;

    // advance the input item when the result register is free or being drained
    assign out_blocked = out_valid_reg && !m_tready;
    assign advance  = in_valid_reg && !out_blocked;
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, mix_reg};

    // select the register for a write and decide between low and high part
    assign sel_eff   = in_byte_reg[7] ? in_byte_reg[6:4] : reg_select_reg;
    assign low_write = in_byte_reg[7] ||
        !((reg_select_reg == SEL_TONE0_PERIOD) || (reg_select_reg == SEL_TONE1_PERIOD) ||
          (reg_select_reg == SEL_TONE2_PERIOD));

    // next state for the item in the input register
    always_comb begin
        tone_period_next = tone_period_reg;
        tone_count_next  = tone_count_reg;
        tone_level_next  = tone_level_reg;
        tone_atten_next  = tone_atten_reg;
        noise_count_next = noise_count_reg;
        noise_shift_next = noise_shift_reg;
        noise_phase_next = noise_phase_reg;
        noise_bit_next   = noise_bit_reg;
        noise_rate_next  = noise_rate_reg;
        noise_white_next = noise_white_reg;
        noise_atten_next = noise_atten_reg;
        reg_select_next  = reg_select_reg;
        noise_dec = (noise_count_reg != 10'd0) ? noise_count_reg - 10'd1 : noise_count_reg;
        for (int i = 0; i < ChCount; i++) begin
            tone_dec[i] = tone_count_reg[i] - 10'd1;
        end

        if (advance) begin
            if (in_action_reg) begin
                // tick: count down the tones, reload and toggle at zero
                for (int i = 0; i < ChCount; i++) begin
                    if (tone_dec[i] == 10'd0) begin
                        tone_count_next[i] = period_or_one(tone_period_reg[i]);
                        tone_level_next[i] = ~tone_level_reg[i];
                    end else begin
                        tone_count_next[i] = tone_dec[i];
                    end
                end
                // tick: noise divider, shift on the rising phase
                noise_count_next = noise_dec;
                if (noise_dec == 10'd0) begin
                    case (noise_rate_reg)
                        NOISE_RATE_16: noise_count_next = 10'h010;
                        NOISE_RATE_32: noise_count_next = 10'h020;
                        NOISE_RATE_64: noise_count_next = 10'h040;
                        default:       noise_count_next = period_or_one(tone_period_reg[2]);
                    endcase
                    noise_phase_next = ~noise_phase_reg;
                    if (!noise_phase_reg) begin
                        noise_bit_next   = noise_shift_reg[0];
                        noise_shift_next = {noise_white_reg ?
                                            (noise_shift_reg[0] ^ noise_shift_reg[3]) :
                                            noise_shift_reg[0],
                                            noise_shift_reg[15:1]};
                    end
                end
            end else begin
                reg_select_next = sel_eff;
                if (low_write) begin
                    // write the low part of the selected register
                    case (sel_eff)
                        SEL_TONE0_PERIOD, SEL_TONE1_PERIOD, SEL_TONE2_PERIOD: begin
                            for (int i = 0; i < ChCount; i++) begin
                                if (sel_eff[2:1] == 2'(i)) begin
                                    tone_period_next[i] = {tone_period_reg[i][9:4],
                                                           in_byte_reg[3:0]};
                                end
                            end
                        end
                        SEL_TONE0_ATTEN, SEL_TONE1_ATTEN, SEL_TONE2_ATTEN: begin
                            for (int i = 0; i < ChCount; i++) begin
                                if (sel_eff[2:1] == 2'(i)) begin
                                    tone_atten_next[i] = in_byte_reg[3:0];
                                end
                            end
                        end
                        SEL_NOISE_CTRL: begin
                            noise_rate_next  = in_byte_reg[1:0];
                            noise_white_next = in_byte_reg[2];
                            noise_shift_next = NOISE_SEED;
                        end
                        default: begin
                            noise_atten_next = in_byte_reg[3:0];
                        end
                    endcase
                end else begin
                    // write the upper six bits of the selected tone period
                    for (int i = 0; i < ChCount; i++) begin
                        if (reg_select_reg[2:1] == 2'(i)) begin
                            tone_period_next[i] = {in_byte_reg[5:0], tone_period_reg[i][3:0]};
                        end
                    end
                end
            end
        end
    end

    // mix the updated channels and divide by four, rounding down
    assign mix_sum = vol_term(tone_atten_next[0], tone_level_next[0]) +
                     vol_term(tone_atten_next[1], tone_level_next[1]) +
                     vol_term(tone_atten_next[2], tone_level_next[2]) +
                     vol_term(noise_atten_next, noise_bit_next);
    assign mix_next = mix_sum[15:2];

    // flag that every tone counter holds a nonzero value
    assign tone_count_ok = (tone_count_reg[0] != 10'd0) && (tone_count_reg[1] != 10'd0) &&
                           (tone_count_reg[2] != 10'd0);

    // hold control and generator state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            for (int i = 0; i < ChCount; i++) begin
                tone_period_reg[i] <= '0;
                tone_count_reg[i]  <= COUNT_FIRST;
                tone_level_reg[i]  <= 1'b0;
                tone_atten_reg[i]  <= ATTEN_MUTE;
            end
            noise_count_reg <= '0;
            noise_shift_reg <= NOISE_SEED;
            noise_phase_reg <= 1'b0;
            noise_bit_reg   <= 1'b0;
            noise_rate_reg  <= NOISE_RATE_16;
            noise_white_reg <= 1'b0;
            noise_atten_reg <= ATTEN_MUTE;
            reg_select_reg  <= SEL_TONE0_PERIOD;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            tone_period_reg <= tone_period_next;
            tone_count_reg  <= tone_count_next;
            tone_level_reg  <= tone_level_next;
            tone_atten_reg  <= tone_atten_next;
            noise_count_reg <= noise_count_next;
            noise_shift_reg <= noise_shift_next;
            noise_phase_reg <= noise_phase_next;
            noise_bit_reg   <= noise_bit_next;
            noise_rate_reg  <= noise_rate_next;
            noise_white_reg <= noise_white_next;
            noise_atten_reg <= noise_atten_next;
            reg_select_reg  <= reg_select_next;
        end
    end

    // load the input item and the result sample
    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_action_reg <= s_tuser;
            in_byte_reg   <= s_tdata;
        end
        if (advance) begin
            mix_reg <= mix_next;
        end
    end

    // a stalled result with a waiting item blocks the input
    `PSG_ASSERT_IMP(a_stall_blocks, aclk, aresetn, in_valid_reg && out_blocked, !s_tready)
    // an advanced item shows up as a result in the next cycle
    `PSG_ASSERT_NXT(a_advance_result, aclk, aresetn, advance, out_valid_reg)
    // the noise shift register never locks up at zero
    `PSG_ASSERT_IMP(a_noise_alive, aclk, aresetn, 1'b1, noise_shift_reg != 16'h0000)
    // tone counters never rest at zero
    `PSG_ASSERT_IMP(a_tone_count_nz, aclk, aresetn, 1'b1, tone_count_ok)

endmodule

// ----- test/tb_top.sv -----
// Self-checking testbench for the tone and noise generator: stream driver, monitor and sample predictor
module tb_top
    import psg_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_TICK  = 1'b1;
    localparam int   WATCHDOG_LIMIT = 4000;
    localparam int   STALL_CYCLES   = 240;
    localparam int   DRAIN_CYCLES   = 8;

    typedef struct packed {
        logic       act;
        logic [7:0] data;
    } psg_item_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;   // [7:0] data_byte
    logic        s_tuser  = 1'b0;    // [0] action (1 = tick, 0 = port write)
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;            // [13:0] mixed_sample (signed), [15:14] zero

    psg_tone_noise_generator uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #4 aclk = ~aclk;

    // stimulus and expected samples
    psg_item_t              stim_q[$];
    logic signed [13:0]     sample_q[$];
    logic signed [13:0]     want_sample;
    int                     n_items;
    int                     sent_cnt    = 0;
    int                     tick_cnt    = 0;
    int                     write_cnt   = 0;
    int                     checked_cnt = 0;
    int                     fail_cnt    = 0;
    int                     quiet_cycles = 0;
    int                     hold_left   = 0;
    logic                   hold_done   = 1'b0;
    int                     send_pct;
    int                     recv_pct;

    // predictor state
    logic [9:0]  p_period [3];
    logic [9:0]  p_count  [3];
    logic        p_level  [3];
    logic [3:0]  p_atten  [3];
    logic [9:0]  nz_count;
    logic [15:0] nz_lfsr;
    logic        nz_phase;
    logic        nz_out;
    logic [1:0]  nz_rate;
    logic        nz_white;
    logic [3:0]  nz_atten;
    logic [2:0]  sel_reg;

    int vol_lin [16] = '{4096, 3254, 2584, 2053, 1631, 1295, 1029, 817,
                         649, 516, 410, 325, 258, 205, 163, 0};

    // write the low four bits of the selected register
    function automatic void pred_low_write(input logic [7:0] wr);
        case (sel_reg)
            SEL_TONE0_PERIOD, SEL_TONE1_PERIOD, SEL_TONE2_PERIOD: begin
                p_period[sel_reg[2:1]][3:0] = wr[3:0];
            end
            SEL_TONE0_ATTEN, SEL_TONE1_ATTEN, SEL_TONE2_ATTEN: begin
                p_atten[sel_reg[2:1]] = wr[3:0];
            end
            SEL_NOISE_CTRL: begin
                nz_rate  = wr[1:0];
                nz_white = wr[2];
                nz_lfsr  = NOISE_SEED;
            end
            default: begin
                nz_atten = wr[3:0];
            end
        endcase
    endfunction

    // apply one item to the predicted state and return the mixed sample
    function automatic logic signed [13:0] psg_next_sample(input logic act,
                                                           input logic [7:0] wr);
        int   sum;
        int   i;
        logic fb;
        if (act == ACT_TICK) begin
            for (i = 0; i < 3; i++) begin
                p_count[i] = p_count[i] - 10'd1;
                if (p_count[i] == 10'd0) begin
                    p_count[i] = (p_period[i] == 10'd0) ? 10'd1 : p_period[i];
                    p_level[i] = ~p_level[i];
                end
            end
            if (nz_count != 10'd0)
                nz_count = nz_count - 10'd1;
            if (nz_count == 10'd0) begin
                case (nz_rate)
                    NOISE_RATE_16: nz_count = 10'd16;
                    NOISE_RATE_32: nz_count = 10'd32;
                    NOISE_RATE_64: nz_count = 10'd64;
                    default:       nz_count = (p_period[2] == 10'd0) ? 10'd1 : p_period[2];
                endcase
                nz_phase = ~nz_phase;
                if (nz_phase) begin
                    fb      = nz_white ? (nz_lfsr[0] ^ nz_lfsr[3]) : nz_lfsr[0];
                    nz_out  = nz_lfsr[0];
                    nz_lfsr = {fb, nz_lfsr[15:1]};
                end
            end
        end else if (wr[7]) begin
            sel_reg = wr[6:4];
            pred_low_write(wr);
        end else if (!sel_reg[0] && sel_reg != SEL_NOISE_CTRL) begin
            p_period[sel_reg[2:1]][9:4] = wr[5:0];
        end else begin
            pred_low_write(wr);
        end
        // signed mix, floored division by four
        sum = 0;
        for (i = 0; i < 3; i++)
            sum += p_level[i] ? vol_lin[p_atten[i]] : -vol_lin[p_atten[i]];
        sum += nz_out ? vol_lin[nz_atten] : -vol_lin[nz_atten];
        return 14'(sum >>> 2);
    endfunction

    // idle rates per phase of the run
    always_comb begin
        if (sent_cnt * 3 < n_items) begin
            send_pct = 16;
            recv_pct = 87;
        end else if (sent_cnt * 3 < n_items * 2) begin
            send_pct = 87;
            recv_pct = 16;
        end else begin
            send_pct = 0;
            recv_pct = 0;
        end
    end

    // driver: predict on acceptance, offer the next pending item
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                sample_q.push_back(psg_next_sample(s_tuser, s_tdata));
                void'(stim_q.pop_front());
                sent_cnt++;
                if (s_tuser == ACT_TICK)
                    tick_cnt++;
                else
                    write_cnt++;
            end
            if (!s_tvalid || s_tready) begin
                if (stim_q.size() != 0 && $urandom_range(99) >= send_pct) begin
                    s_tvalid <= 1'b1;
                    s_tuser  <= stim_q[0].act;
                    s_tdata  <= stim_q[0].data;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // long output stall once in the last phase, so the input backs up
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left <= 0;
        end else if (!hold_done && sent_cnt * 4 >= n_items * 3) begin
            hold_left <= STALL_CYCLES;
            hold_done <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // receiver ready
    always @(posedge aclk) begin
        if (!aresetn)
            m_tready <= 1'b0;
        else
            m_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_pct);
    end

    // monitor: compare each sample with the oldest prediction
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (sample_q.size() == 0) begin
                $error("mixed_sample: no sample expected, actual %0d", $signed(m_tdata[13:0]));
                fail_cnt++;
            end else begin
                want_sample = sample_q.pop_front();
                checked_cnt++;
                if (m_tdata[13:0] !== want_sample) begin
                    $error("mixed_sample: expected %0d, actual %0d",
                           want_sample, $signed(m_tdata[13:0]));
                    fail_cnt++;
                end
            end
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no handshake for %0d cycles", quiet_cycles);
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        psg_item_t it;
        int        roll;
        int        burst;
        int        k;

        // predictor reset state
        for (k = 0; k < 3; k++) begin
            p_period[k] = 10'd0;
            p_count[k]  = COUNT_FIRST;
            p_level[k]  = 1'b0;
            p_atten[k]  = ATTEN_MUTE;
        end
        nz_count = 10'd0;
        nz_lfsr  = NOISE_SEED;
        nz_phase = 1'b0;
        nz_out   = 1'b0;
        nz_rate  = NOISE_RATE_16;
        nz_white = 1'b0;
        nz_atten = ATTEN_MUTE;
        sel_reg  = SEL_TONE0_PERIOD;

        // directed part
        // open all channels at full volume, tick on zero periods
        stim_q.push_back('{ACT_WRITE, 8'h90});
        stim_q.push_back('{ACT_WRITE, 8'hB0});
        stim_q.push_back('{ACT_WRITE, 8'hD0});
        stim_q.push_back('{ACT_WRITE, 8'hF0});
        stim_q.push_back('{ACT_TICK,  8'hFF});
        stim_q.push_back('{ACT_TICK,  8'h00});
        // tone 0 to the largest period, tone 1 to zero, tone 2 to one
        stim_q.push_back('{ACT_WRITE, 8'h8F});
        stim_q.push_back('{ACT_WRITE, 8'h3F});
        stim_q.push_back('{ACT_WRITE, 8'hA0});
        stim_q.push_back('{ACT_WRITE, 8'h00});
        stim_q.push_back('{ACT_WRITE, 8'hC1});
        stim_q.push_back('{ACT_WRITE, 8'h40});
        // noise clocked from tone 2, periodic
        stim_q.push_back('{ACT_WRITE, 8'hE3});
        stim_q.push_back('{ACT_TICK,  8'h00});
        stim_q.push_back('{ACT_TICK,  8'h55});
        stim_q.push_back('{ACT_TICK,  8'hAA});
        // data byte on noise control: white, reseed
        stim_q.push_back('{ACT_WRITE, 8'h07});
        stim_q.push_back('{ACT_TICK,  8'h00});
        stim_q.push_back('{ACT_TICK,  8'h00});
        // data byte on an attenuation acts as a low write
        stim_q.push_back('{ACT_WRITE, 8'h9F});
        stim_q.push_back('{ACT_WRITE, 8'h05});
        stim_q.push_back('{ACT_WRITE, 8'hFF});
        stim_q.push_back('{ACT_WRITE, 8'h7A});
        stim_q.push_back('{ACT_WRITE, 8'hE4});
        stim_q.push_back('{ACT_TICK,  8'h00});

        // random part: mostly ticks, small tone periods, some tick bursts
        while (stim_q.size() < 1025) begin
            roll = $urandom_range(99);
            if (roll < 5) begin
                burst = $urandom_range(40, 8);
                for (k = 0; k < burst; k++) begin
                    it.act  = ACT_TICK;
                    it.data = 8'($urandom_range(255));
                    stim_q.push_back(it);
                end
            end else if (roll < 57) begin
                it.act  = ACT_TICK;
                it.data = 8'($urandom_range(255));
                stim_q.push_back(it);
            end else if (roll < 82) begin
                it.act  = ACT_WRITE;
                it.data = 8'h80 | 8'($urandom_range(127));
                stim_q.push_back(it);
            end else begin
                it.act  = ACT_WRITE;
                it.data = ($urandom_range(3) != 0) ? 8'($urandom_range(3))
                                                    : 8'($urandom_range(127));
                stim_q.push_back(it);
            end
        end
        n_items = stim_q.size();

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // wait for all items and samples, then drain
        while (stim_q.size() != 0 || sample_q.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d items (%0d ticks, %0d port writes) over three idling phases",
                 sent_cnt, tick_cnt, write_cnt);
        $display("and one long output stall; %0d samples compared, %0d failures.",
                 checked_cnt, fail_cnt);
        if (fail_cnt == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ----- psg_tone_noise_generator.f -----
+incdir+sv
sv/psg_pkg.sv
sv/psg_tone_noise_generator.sv
test/tb_top.sv
